// ===== sv/heightmap_vertex_normal_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Heightmap vertex normal generator assertion macros
// Shared property shapes for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMAL_GENERATOR_DEFINES_SVH
`define HEIGHTMAP_VERTEX_NORMAL_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HVN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hvn same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HVN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hvn next-cycle check failed");

`endif

// ===== sv/hvn_pkg.sv =====
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared constants and the vertex job type for the heightmap normal generator.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MaxWidth = 4096;
  localparam int ColW     = 12;
  localparam int RowW     = 16;
  localparam int ElevW    = 24;
  localparam int ZW       = 16;
  localparam int DzW      = 17;
  localparam int DivNW    = 48;
  localparam int DivDW    = 33;
  localparam int DivCntW  = 6;
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;

  localparam logic signed [ZW-1:0] ZOffset     = 16'sd6554;
  localparam logic        [15:0]   CoordOffset = 16'd16384;
  localparam logic signed [15:0]   NormOne     = 16'sd16384;

  // Configuration register indexes.
  localparam logic [1:0] CfgGridWidth  = 2'd0;
  localparam logic [1:0] CfgGridHeight = 2'd1;
  localparam logic [1:0] CfgElevMin    = 2'd2;
  localparam logic [1:0] CfgElevMax    = 2'd3;

  // One vertex to be finished by the back end.
  typedef struct packed {
    logic [RowW-1:0]       row;
    logic [ColW-1:0]       col;
    logic signed [ZW-1:0]  z;
    logic [ColW-1:0]       ca;
    logic [ColW-1:0]       cb;
    logic [RowW-1:0]       ra;
    logic [RowW-1:0]       rb;
    logic signed [DzW-1:0] dzx;
    logic signed [DzW-1:0] dzy;
    logic                  last;
  } job_t;

endpackage

// ===== sv/heightmap_vertex_normal_generator.sv =====
// A sample in any row after the first yields one to three vertices; samples of row zero give
// no vertex. The front end takes no new sample until it is through with the last one, and
// it waits while the queue is full; the back end finishes one vertex at a time, and skips
// the square root and the division when the normal is degenerate.
// Reset clears counters, sequencers and the queue; row buffers are not cleared.
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_generator
// Raster-order elevation in, grid vertices with Q1.15 positions and Q1.14
// unit normals out.
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normal_generator_defines.svh"

module heightmap_vertex_normal_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] elevation_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        vertex_row_o,
  output logic [11:0]        vertex_col_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic [14:0]        norm_z_o,
  output logic               last_vertex_o
);

  logic [12:0]                    grid_width_q;
  logic [15:0]                    grid_height_q;
  logic signed [23:0]             elev_min_q, elev_max_q;
  logic [hvn_pkg::ColW-1:0]       wm1;
  logic [hvn_pkg::RowW-1:0]       hm1;
  logic                           q_push, q_full, q_pop, q_empty;
  hvn_pkg::job_t                  q_in, q_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 13'd4096;
      grid_height_q <= 16'd4096;
      elev_min_q    <= 24'sd0;
      elev_max_q    <= 24'sd8388607;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hvn_pkg::CfgGridWidth:  grid_width_q  <= cfg_wdata_i[12:0];
        hvn_pkg::CfgGridHeight: grid_height_q <= cfg_wdata_i[15:0];
        hvn_pkg::CfgElevMin:    elev_min_q    <= cfg_wdata_i;
        hvn_pkg::CfgElevMax:    elev_max_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective grid size less one, clamped to the supported range.
  always_comb begin
    if (grid_width_q < 13'd2)                       wm1 = hvn_pkg::ColW'(1);
    else if (grid_width_q > 13'(hvn_pkg::MaxWidth)) wm1 = hvn_pkg::ColW'(hvn_pkg::MaxWidth - 1);
    else                                            wm1 = hvn_pkg::ColW'(grid_width_q - 13'd1);
    hm1 = (grid_height_q < 16'd2) ? 16'd1 : grid_height_q - 16'd1;
  end

  hvn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .elevation_i (elevation_i),
    .wm1_i       (wm1),
    .hm1_i       (hm1),
    .elev_min_i  (elev_min_q),
    .elev_max_i  (elev_max_q),
    .push_o      (q_push),
    .job_o       (q_in),
    .full_i      (q_full)
  );

  hvn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_out),
    .empty_o (q_empty)
  );

  hvn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .job_i         (q_out),
    .pop_o         (q_pop),
    .wm1_i         (wm1),
    .hm1_i         (hm1),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .vertex_row_o  (vertex_row_o),
    .vertex_col_o  (vertex_col_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .norm_z_o      (norm_z_o),
    .last_vertex_o (last_vertex_o)
  );

  // The front end never pushes into a full queue.
  `HVN_ASSERT_SAME(a_queue_no_overflow, q_push, !q_full)
  // An accepted sample keeps the front end busy in the following cycle.
  `HVN_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // A unit normal never has a z component above one.
  `HVN_ASSERT_SAME(a_norm_z_bound, out_valid_o, norm_z_o <= 15'd16384)

endmodule

// ===== sv/hvn_div.sv =====
// ----------------------------------------------------------------------------
// hvn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hvn_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [hvn_pkg::DivNW-1:0]      dividend_i,
  input  logic [hvn_pkg::DivDW-1:0]      divisor_i,
  output logic                           done_o,
  output logic [hvn_pkg::DivNW-1:0]      quotient_o
);

  logic [hvn_pkg::DivNW-1:0]   dvd_q;
  logic [hvn_pkg::DivDW-1:0]   dsr_q;
  logic [hvn_pkg::DivDW-1:0]   rem_q;
  logic [hvn_pkg::DivCntW-1:0] cnt_q;
  logic                        done_q;
  logic [hvn_pkg::DivDW:0]     rem_sh;
  logic                        ge;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh = {rem_q, dvd_q[hvn_pkg::DivNW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == hvn_pkg::DivCntW'(1));
      if (start_i) begin
        cnt_q <= hvn_pkg::DivCntW'(hvn_pkg::DivNW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - hvn_pkg::DivCntW'(1);
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[hvn_pkg::DivNW-2:0], ge};
      rem_q <= ge ? hvn_pkg::DivDW'(rem_sh - {1'b0, dsr_q}) : rem_sh[hvn_pkg::DivDW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== sv/hvn_queue.sv =====
// ----------------------------------------------------------------------------
// hvn_queue
// Short job queue between the sample front end and the vertex back end.
// ----------------------------------------------------------------------------
module hvn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hvn_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output hvn_pkg::job_t job_o,
  output logic          empty_o
);

  hvn_pkg::job_t                mem_q [hvn_pkg::QDepth];
  logic [hvn_pkg::QPtrW-1:0]    wr_ptr_q;
  logic [hvn_pkg::QPtrW-1:0]    rd_ptr_q;
  logic [hvn_pkg::QPtrW:0]      cnt_q;

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + hvn_pkg::QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + hvn_pkg::QPtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (hvn_pkg::QPtrW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (hvn_pkg::QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  assign job_o   = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == (hvn_pkg::QPtrW+1)'(hvn_pkg::QDepth));
  assign empty_o = (cnt_q == '0);

endmodule

// ===== sv/hvn_front.sv =====
// ----------------------------------------------------------------------------
// hvn_front
// Accepts elevation samples, scales them, keeps the two row buffers and
// queues up to three vertex jobs per sample.
// ----------------------------------------------------------------------------
module hvn_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [hvn_pkg::ElevW-1:0]   elevation_i,
  input  logic [hvn_pkg::ColW-1:0]           wm1_i,
  input  logic [hvn_pkg::RowW-1:0]           hm1_i,
  input  logic signed [hvn_pkg::ElevW-1:0]   elev_min_i,
  input  logic signed [hvn_pkg::ElevW-1:0]   elev_max_i,
  output logic                               push_o,
  output hvn_pkg::job_t                      job_o,
  input  logic                               full_i
);

  localparam logic [2:0] FIdle  = 3'd0;
  localparam logic [2:0] FZDiv  = 3'd1;
  localparam logic [2:0] FRead  = 3'd2;
  localparam logic [2:0] FPush  = 3'd3;
  localparam logic [2:0] FWrite = 3'd4;

  logic [2:0]                       state_q;
  logic [hvn_pkg::ColW-1:0]         colcnt_q, col_q;
  logic [hvn_pkg::RowW-1:0]         rowcnt_q, row_q;
  logic signed [hvn_pkg::ZW-1:0]    z_q, mid_q, up_q, right_q, zc_q, zu_q, zcl_q, prev_z_q;
  logic signed [hvn_pkg::ZW-1:0]    newer_rd_q, older_rd_q;
  logic signed [hvn_pkg::ZW-1:0]    newer_mem [hvn_pkg::MaxWidth];
  logic signed [hvn_pkg::ZW-1:0]    older_mem [hvn_pkg::MaxWidth];
  logic [2:0]                       rd_cnt_q;
  logic [1:0]                       job_idx_q;
  logic                             flat_q;
  logic                             accept, wr_en, need, last_row;
  logic [hvn_pkg::ColW-1:0]         col_sel, rd_addr;
  logic [hvn_pkg::RowW-1:0]         row_sel, r0;
  logic signed [24:0]               e_s, mn_s, mx_s, e_cl, diff, rng;
  logic [hvn_pkg::DivNW-1:0]        rng_u, dividend, quotient;
  logic [hvn_pkg::DivDW-1:0]        divisor;
  logic                             div_done, flat;
  logic signed [hvn_pkg::ZW-1:0]    za, zb, zra;

  assign accept     = in_valid_i && (state_q == FIdle);
  assign in_stall_o = (state_q != FIdle);
  assign col_sel    = (colcnt_q < wm1_i) ? colcnt_q : wm1_i;
  assign row_sel    = (rowcnt_q < hm1_i) ? rowcnt_q : hm1_i;

  // Height scaling: z = floor((131072*(e-min) + 9*d) / (10*d)) - 6554.
  always_comb begin
    e_s      = {elevation_i[hvn_pkg::ElevW-1], elevation_i};
    mn_s     = {elev_min_i[hvn_pkg::ElevW-1], elev_min_i};
    mx_s     = {elev_max_i[hvn_pkg::ElevW-1], elev_max_i};
    flat     = (mx_s <= mn_s);
    e_cl     = (e_s < mn_s) ? mn_s : ((e_s > mx_s) ? mx_s : e_s);
    diff     = e_cl - mn_s;
    rng      = mx_s - mn_s;
    rng_u    = hvn_pkg::DivNW'(rng[24:0]);
    dividend = (hvn_pkg::DivNW'(diff[23:0]) << 17) + (rng_u << 3) + rng_u;
    divisor  = hvn_pkg::DivDW'((rng_u << 3) + (rng_u << 1));
  end

  hvn_div u_zdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Row buffer read address sequence: mid, right, left-of-col, two-left.
  always_comb begin
    case (rd_cnt_q)
      3'd0:    rd_addr = col_q;
      3'd1:    rd_addr = col_q + hvn_pkg::ColW'(1);
      3'd2:    rd_addr = col_q - hvn_pkg::ColW'(1);
      3'd3:    rd_addr = col_q - hvn_pkg::ColW'(2);
      default: rd_addr = col_q;
    endcase
  end

  assign wr_en = (state_q == FWrite);

  // Row buffers: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      newer_mem[col_q] <= z_q;
      if (row_q != '0) older_mem[col_q] <= mid_q;
    end
    newer_rd_q <= newer_mem[rd_addr];
    older_rd_q <= older_mem[rd_addr];
  end

  assign last_row = (row_q == hm1_i);
  assign r0       = row_q - hvn_pkg::RowW'(1);

  // Build the job selected by the push index.
  always_comb begin
    job_o  = '0;
    need   = 1'b0;
    za     = '0;
    zb     = '0;
    zra    = '0;
    case (job_idx_q)
      2'd0: begin
        need       = 1'b1;
        job_o.row  = r0;
        job_o.col  = col_q;
        job_o.z    = mid_q;
        if (col_q != '0 && col_q < wm1_i) begin
          job_o.ca = col_q - hvn_pkg::ColW'(1);
          za       = prev_z_q;
          job_o.cb = col_q + hvn_pkg::ColW'(1);
          zb       = right_q;
        end else if (col_q < wm1_i) begin
          job_o.ca = col_q;
          za       = mid_q;
          job_o.cb = col_q + hvn_pkg::ColW'(1);
          zb       = right_q;
        end else begin
          job_o.ca = col_q - hvn_pkg::ColW'(1);
          za       = prev_z_q;
          job_o.cb = col_q;
          zb       = mid_q;
        end
        job_o.ra  = (r0 != '0) ? r0 - hvn_pkg::RowW'(1) : r0;
        zra       = (r0 != '0) ? up_q : mid_q;
        job_o.rb  = row_q;
        job_o.dzx = hvn_pkg::DzW'(zb) - hvn_pkg::DzW'(za);
        job_o.dzy = hvn_pkg::DzW'(z_q) - hvn_pkg::DzW'(zra);
      end
      2'd1: begin
        need      = last_row && (col_q != '0);
        job_o.row = row_q;
        job_o.col = col_q - hvn_pkg::ColW'(1);
        job_o.z   = zc_q;
        if (col_q > hvn_pkg::ColW'(1)) begin
          job_o.ca = col_q - hvn_pkg::ColW'(2);
          za       = zcl_q;
        end else begin
          job_o.ca = col_q - hvn_pkg::ColW'(1);
          za       = zc_q;
        end
        job_o.cb  = col_q;
        job_o.ra  = r0;
        job_o.rb  = row_q;
        job_o.dzx = hvn_pkg::DzW'(z_q) - hvn_pkg::DzW'(za);
        job_o.dzy = hvn_pkg::DzW'(zc_q) - hvn_pkg::DzW'(zu_q);
      end
      2'd2: begin
        need       = last_row && (col_q == wm1_i);
        job_o.row  = row_q;
        job_o.col  = col_q;
        job_o.z    = z_q;
        job_o.ca   = col_q - hvn_pkg::ColW'(1);
        job_o.cb   = col_q;
        job_o.ra   = r0;
        job_o.rb   = row_q;
        job_o.dzx  = hvn_pkg::DzW'(z_q) - hvn_pkg::DzW'(zc_q);
        job_o.dzy  = hvn_pkg::DzW'(z_q) - hvn_pkg::DzW'(mid_q);
        job_o.last = 1'b1;
      end
      default: need = 1'b0;
    endcase
  end

  assign push_o = (state_q == FPush) && need && !full_i;

  // Sample sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FIdle;
      colcnt_q  <= '0;
      rowcnt_q  <= '0;
      prev_z_q  <= '0;
      rd_cnt_q  <= '0;
      job_idx_q <= '0;
    end else begin
      case (state_q)
        FIdle: begin
          if (accept) state_q <= FZDiv;
        end
        FZDiv: begin
          if (div_done) begin
            rd_cnt_q <= '0;
            state_q  <= (row_q == '0) ? FWrite : FRead;
          end
        end
        FRead: begin
          if (rd_cnt_q == 3'd4) begin
            job_idx_q <= '0;
            state_q   <= FPush;
          end else begin
            rd_cnt_q <= rd_cnt_q + 3'd1;
          end
        end
        FPush: begin
          if (!need || !full_i) begin
            if (job_idx_q == 2'd2) state_q <= FWrite;
            else job_idx_q <= job_idx_q + 2'd1;
          end
        end
        FWrite: begin
          if (row_q != '0) prev_z_q <= mid_q;
          if (col_q >= wm1_i) begin
            colcnt_q <= '0;
            rowcnt_q <= (row_q >= hm1_i) ? '0 : row_q + hvn_pkg::RowW'(1);
          end else begin
            colcnt_q <= col_q + hvn_pkg::ColW'(1);
            rowcnt_q <= row_q;
          end
          state_q <= FIdle;
        end
        default: state_q <= FIdle;
      endcase
    end
  end

  // Per-sample data registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q  <= col_sel;
      row_q  <= row_sel;
      flat_q <= flat;
    end
    if (state_q == FZDiv && div_done) begin
      z_q <= flat_q ? -hvn_pkg::ZOffset : $signed(quotient[15:0]) - hvn_pkg::ZOffset;
    end
    if (state_q == FRead) begin
      case (rd_cnt_q)
        3'd1: begin
          mid_q <= newer_rd_q;
          up_q  <= older_rd_q;
        end
        3'd2: right_q <= newer_rd_q;
        3'd3: begin
          zc_q <= newer_rd_q;
          zu_q <= older_rd_q;
        end
        3'd4: zcl_q <= newer_rd_q;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/hvn_back.sv =====
// ----------------------------------------------------------------------------
// hvn_back
// Finishes one vertex job: grid coordinates, cross product, its length and
// unit normal (up for a zero product); holds the result until it is taken.
// ----------------------------------------------------------------------------
module hvn_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  hvn_pkg::job_t         job_i,
  output logic                  pop_o,
  input  logic [hvn_pkg::ColW-1:0] wm1_i,
  input  logic [hvn_pkg::RowW-1:0] hm1_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           vertex_row_o,
  output logic [11:0]           vertex_col_o,
  output logic signed [15:0]    pos_x_o,
  output logic signed [15:0]    pos_y_o,
  output logic signed [15:0]    pos_z_o,
  output logic signed [15:0]    norm_x_o,
  output logic signed [15:0]    norm_y_o,
  output logic [14:0]           norm_z_o,
  output logic                  last_vertex_o
);

  localparam logic [2:0] BIdle  = 3'd0;
  localparam logic [2:0] BCoord = 3'd1;
  localparam logic [2:0] BMul   = 3'd2;
  localparam logic [2:0] BSqChk = 3'd3;
  localparam logic [2:0] BSqrt  = 3'd4;
  localparam logic [2:0] BUnit  = 3'd5;
  localparam logic [2:0] BOut   = 3'd6;

  logic [2:0]                  state_q;
  hvn_pkg::job_t               job_q;
  logic [2:0]                  k_q;
  logic                        wait_q;
  logic signed [15:0]          coord_q [6];
  logic signed [33:0]          v_q [3];
  logic [63:0]                 s_q, rem_q, res_q, bit_q;
  logic [4:0]                  sq_cnt_q;
  logic [31:0]                 len_q;
  logic [1:0]                  u_q;
  logic signed [15:0]          nrm_q [3];
  logic                        div_start, div_done;
  logic [hvn_pkg::DivNW-1:0]   dividend, quotient;
  logic [hvn_pkg::DivDW-1:0]   divisor;
  logic [15:0]                 c_idx, c_d;
  logic signed [33:0]          dx, dy, mul_a, mul_b, v_sel;
  logic signed [67:0]          mul_p;
  logic [32:0]                 mag;
  logic [63:0]                 sq_sum, rem_d, res_d;
  logic                        sq_ge;

  assign pop_o = (state_q == BIdle) && !empty_i;

  // Coordinate index and span for the current coordinate step.
  always_comb begin
    case (k_q)
      3'd0:    c_idx = 16'(job_q.col);
      3'd1:    c_idx = 16'(job_q.ca);
      3'd2:    c_idx = 16'(job_q.cb);
      3'd3:    c_idx = job_q.row;
      3'd4:    c_idx = job_q.ra;
      default: c_idx = job_q.rb;
    endcase
    c_d = (k_q < 3'd3) ? 16'(wm1_i) : hm1_i;
  end

  // Magnitude of the component being normalized.
  always_comb begin
    v_sel = v_q[u_q];
    mag   = v_sel[33] ? 33'(-v_sel) : 33'(v_sel);
  end

  // Shared divider: coordinates first, then the three normal components.
  always_comb begin
    if (state_q == BCoord) begin
      dividend = hvn_pkg::DivNW'({c_idx, 16'b0}) + hvn_pkg::DivNW'(c_d);
      divisor  = hvn_pkg::DivDW'({c_d, 1'b0});
    end else begin
      dividend = (hvn_pkg::DivNW'(mag) << 15) + hvn_pkg::DivNW'(len_q);
      divisor  = hvn_pkg::DivDW'({len_q, 1'b0});
    end
  end

  assign div_start = ((state_q == BCoord) || (state_q == BUnit)) && !wait_q;

  hvn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Tangent differences and the shared multiplier.
  always_comb begin
    dx = 34'(coord_q[2]) - 34'(coord_q[1]);
    dy = 34'(coord_q[5]) - 34'(coord_q[4]);
    case (k_q)
      3'd0: begin
        mul_a = 34'(job_q.dzx);
        mul_b = dy;
      end
      3'd1: begin
        mul_a = dx;
        mul_b = 34'(job_q.dzy);
      end
      3'd2: begin
        mul_a = dx;
        mul_b = dy;
      end
      3'd3: begin
        mul_a = v_q[0];
        mul_b = v_q[0];
      end
      3'd4: begin
        mul_a = v_q[1];
        mul_b = v_q[1];
      end
      default: begin
        mul_a = v_q[2];
        mul_b = v_q[2];
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // One step of the bitwise square root.
  always_comb begin
    sq_sum = res_q + bit_q;
    sq_ge  = rem_q >= sq_sum;
    rem_d  = sq_ge ? rem_q - sq_sum : rem_q;
    res_d  = sq_ge ? (res_q >> 1) + bit_q : res_q >> 1;
  end

  // Vertex sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle;
      k_q     <= '0;
      wait_q  <= 1'b0;
      u_q     <= '0;
    end else begin
      case (state_q)
        BIdle: begin
          if (!empty_i) begin
            k_q     <= '0;
            wait_q  <= 1'b0;
            state_q <= BCoord;
          end
        end
        BCoord: begin
          if (div_start) begin
            wait_q <= 1'b1;
          end else if (div_done) begin
            wait_q <= 1'b0;
            if (k_q == 3'd5) begin
              k_q     <= '0;
              state_q <= BMul;
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        BMul: begin
          if (k_q == 3'd5) state_q <= BSqChk;
          else k_q <= k_q + 3'd1;
        end
        BSqChk: begin
          u_q     <= '0;
          wait_q  <= 1'b0;
          state_q <= (s_q == '0) ? BOut : BSqrt;
        end
        BSqrt: begin
          if (sq_cnt_q == 5'd31) state_q <= BUnit;
        end
        BUnit: begin
          if (div_start) begin
            wait_q <= 1'b1;
          end else if (div_done) begin
            wait_q <= 1'b0;
            if (u_q == 2'd2) state_q <= BOut;
            else u_q <= u_q + 2'd1;
          end
        end
        BOut: begin
          if (!out_stall_i) state_q <= BIdle;
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (state_q == BCoord && !div_start && div_done) begin
      coord_q[k_q] <= $signed(quotient[15:0] - hvn_pkg::CoordOffset);
    end
    if (state_q == BMul) begin
      case (k_q)
        3'd0:    v_q[0] <= -mul_p[33:0];
        3'd1:    v_q[1] <= -mul_p[33:0];
        3'd2:    v_q[2] <= mul_p[33:0];
        3'd3:    s_q    <= mul_p[63:0];
        default: s_q    <= s_q + mul_p[63:0];
      endcase
    end
    if (state_q == BSqChk) begin
      rem_q    <= s_q;
      res_q    <= '0;
      bit_q    <= 64'h4000_0000_0000_0000;
      sq_cnt_q <= '0;
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= hvn_pkg::NormOne;
    end
    if (state_q == BSqrt) begin
      rem_q    <= rem_d;
      res_q    <= res_d;
      bit_q    <= bit_q >> 2;
      sq_cnt_q <= sq_cnt_q + 5'd1;
      if (sq_cnt_q == 5'd31) len_q <= res_d[31:0];
    end
    if (state_q == BUnit && !div_start && div_done) begin
      nrm_q[u_q] <= v_sel[33] ? -$signed(quotient[15:0]) : $signed(quotient[15:0]);
    end
  end

  assign out_valid_o   = (state_q == BOut);
  assign vertex_row_o  = job_q.row;
  assign vertex_col_o  = job_q.col;
  assign pos_x_o       = coord_q[0];
  assign pos_y_o       = coord_q[3];
  assign pos_z_o       = job_q.z;
  assign norm_x_o      = nrm_q[0];
  assign norm_y_o      = nrm_q[1];
  assign norm_z_o      = nrm_q[2][14:0];
  assign last_vertex_o = job_q.last;

endmodule
